/* rtl/tro_pkg.sv */
// Package for the trimmed ratio optimizer: widths, reset values, register
// indexes and the command/status structs shared by controller and datapath.
// No dependencies.
`default_nettype none
package tro_pkg;

  localparam int DefMaxPoints = 1024;
  localparam int DistW        = 32;
  localparam int CfgW         = 16;
  localparam int CfgIdxW      = 2;
  localparam int CntOutW      = 11;
  localparam int RatioW       = 16;

  localparam logic [CfgW-1:0] MinRatioRst = 16'd3277;
  localparam logic [CfgW-1:0] MaxRatioRst = 16'd64881;
  localparam logic [CfgW-1:0] PenaltyRst  = 16'd9011;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_RATIO = 2'd0,
    CFG_MAX_RATIO = 2'd1,
    CFG_PENALTY   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LOG_N   = 2'd0,
    LOG_ID  = 2'd1,
    LOG_SUM = 2'd2
  } log_sel_e;

  typedef struct packed {
    logic     load;
    logic     ins_rd;
    logic     ins_shift;
    logic     ins_put;
    logic     setup;
    logic     log_go;
    log_sel_e log_sel;
    logic     pre_rd;
    logic     pre_acc;
    logic     cand_init;
    logic     cand_rd;
    logic     cand_acc;
    logic     pen;
    logic     cost;
    logic     div_init;
    logic     div_step;
    logic     fin;
  } tro_cmd_t;

  typedef struct packed {
    logic keep;
    logic last;
    logic i_zero;
    logic gt;
    logic n_zero;
    logic k_lt;
    logic id_le;
    logic log_done;
    logic div_done;
  } tro_status_t;

endpackage
`default_nettype wire

/* rtl/tro_log2.sv */
// Iterative log2 approximation: leading-one search, one bit per cycle.
// Result is {exponent, 16 fraction bits after the leading one}. Uses tro_pkg.
`default_nettype none
module tro_log2 import tro_pkg::*; #(
  parameter int SumW = 43
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [SumW-1:0]             x_i,
  output logic                             done_o,
  output logic [$clog2(SumW)+16-1:0]       res_o
);
  localparam int EW = $clog2(SumW);
  localparam int LW = EW + 16;

  logic            busy_q;
  logic            done_q;
  logic [SumW-1:0] m_q;
  logic [EW-1:0]   e_q;
  logic [LW-1:0]   res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      m_q    <= '0;
      e_q    <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        m_q    <= x_i;
        e_q    <= EW'(SumW - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (m_q[SumW-1] || (e_q == '0)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_q  <= {e_q, m_q[SumW-2 -: 16]};
        end else begin
          m_q <= m_q << 1;
          e_q <= e_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
`default_nettype wire

/* rtl/tro_ctrl.sv */
// Controller state machine: sequences insertion, search and division.
// Uses tro_pkg command and status structs.
`default_nettype none
module tro_ctrl import tro_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire tro_status_t sts_i,
  output tro_cmd_t         cmd_o
);
  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_INS_RD   = 19'h00002,
    S_INS_CMP  = 19'h00004,
    S_POST     = 19'h00008,
    S_SETUP    = 19'h00010,
    S_LN_GO    = 19'h00020,
    S_LN_WT    = 19'h00040,
    S_PRE_RD   = 19'h00080,
    S_PRE_ACC  = 19'h00100,
    S_CAND_RD  = 19'h00200,
    S_CAND_ACC = 19'h00400,
    S_LI_GO    = 19'h00800,
    S_LI_WT    = 19'h01000,
    S_LS_GO    = 19'h02000,
    S_LS_WT    = 19'h04000,
    S_PEN      = 19'h08000,
    S_COST     = 19'h10000,
    S_DIV      = 19'h20000,
    S_OUT      = 19'h40000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.log_sel = LOG_N;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (!sts_i.keep) begin
          state_d = S_POST;
        end else if (sts_i.i_zero) begin
          cmd_o.ins_put = 1'b1;
          state_d       = S_POST;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.gt) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = S_INS_RD;
        end else begin
          cmd_o.ins_put = 1'b1;
          state_d       = S_POST;
        end
      end
      S_POST: state_d = sts_i.last ? S_SETUP : S_IDLE;
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = sts_i.n_zero ? S_OUT : S_LN_GO;
      end
      S_LN_GO: begin
        cmd_o.log_go = 1'b1;
        state_d      = S_LN_WT;
      end
      S_LN_WT: begin
        if (sts_i.log_done) state_d = S_PRE_RD;
      end
      S_PRE_RD: begin
        if (sts_i.k_lt) begin
          cmd_o.pre_rd = 1'b1;
          state_d      = S_PRE_ACC;
        end else begin
          cmd_o.cand_init = 1'b1;
          state_d         = S_CAND_RD;
        end
      end
      S_PRE_ACC: begin
        cmd_o.pre_acc = 1'b1;
        state_d       = S_PRE_RD;
      end
      S_CAND_RD: begin
        if (sts_i.id_le) begin
          cmd_o.cand_rd = 1'b1;
          state_d       = S_CAND_ACC;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_CAND_ACC: begin
        cmd_o.cand_acc = 1'b1;
        state_d        = S_LI_GO;
      end
      S_LI_GO: begin
        cmd_o.log_go  = 1'b1;
        cmd_o.log_sel = LOG_ID;
        state_d       = S_LI_WT;
      end
      S_LI_WT: begin
        cmd_o.log_sel = LOG_ID;
        if (sts_i.log_done) state_d = S_LS_GO;
      end
      S_LS_GO: begin
        cmd_o.log_go  = 1'b1;
        cmd_o.log_sel = LOG_SUM;
        state_d       = S_LS_WT;
      end
      S_LS_WT: begin
        cmd_o.log_sel = LOG_SUM;
        if (sts_i.log_done) state_d = S_PEN;
      end
      S_PEN: begin
        cmd_o.pen = 1'b1;
        state_d   = S_COST;
      end
      S_COST: begin
        cmd_o.cost = 1'b1;
        state_d    = S_CAND_RD;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.fin = 1'b1;
          state_d   = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

`ifndef SYNTH
  a_out_after_setup_or_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_SETUP || $past(state_q) == S_DIV))
    else $error("result raised outside setup or divide");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == S_IDLE && !out_valid_o))
    else $error("input taken while busy");
  a_log_wait_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.log_go |=> (cmd_o.log_sel == $past(cmd_o.log_sel)))
    else $error("log select changed during conversion");
`endif
endmodule
`default_nettype wire

/* rtl/tro_datapath.sv */
// Datapath: config registers, sorted distance store, prefix sum, cost compare
// and restoring divider. Uses tro_pkg and tro_log2.
`default_nettype none
module tro_datapath import tro_pkg::*; #(
  parameter int MaxPoints = DefMaxPoints
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  input  wire logic [DistW-1:0]    distance_i,
  input  wire logic                is_infinite_i,
  input  wire logic                last_i,
  input  wire tro_cmd_t            cmd_i,
  output tro_status_t              sts_o,
  output logic [CntOutW-1:0]       kept_count_o,
  output logic [CntOutW-1:0]       total_count_o,
  output logic [RatioW-1:0]        ratio_o,
  output logic                     empty_error_o
);
  localparam int AW    = $clog2(MaxPoints);
  localparam int CW    = $clog2(MaxPoints + 1);
  localparam int SW    = DistW + AW + 1;
  localparam int EW    = $clog2(SW);
  localparam int LW    = EW + 16;
  localparam int PW    = CfgW + 1 + LW - 12;
  localparam int CostW = PW + 1;
  localparam int CmpW  = (CostW > 32) ? CostW : 32;
  localparam int DivW  = CW + 16;
  localparam int DcW   = $clog2(DivW + 1);

  // config
  logic [CfgW-1:0] min_ratio_q, max_ratio_q, lambda_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ratio_q <= MinRatioRst;
      max_ratio_q <= MaxRatioRst;
      lambda_q    <= PenaltyRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_RATIO: min_ratio_q <= cfg_data_i;
        CFG_MAX_RATIO: max_ratio_q <= cfg_data_i;
        CFG_PENALTY:   lambda_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // distance store
  logic [DistW-1:0] mem [MaxPoints];
  logic [DistW-1:0] rd_q;
  logic [AW-1:0]    raddr, waddr;
  logic [DistW-1:0] wdata;
  logic             re, we;

  logic [DistW-1:0] d_q;
  logic             keep_q, last_q;
  logic [CW-1:0]    count_q, i_q, n_q, k_q, id_q, min_el_q, max_el_q, best_idx_q, kept_q;
  logic [SW-1:0]    sum_q;
  logic [LW-1:0]    ln_q, li_q, ls_q;
  logic [PW-1:0]    pen_q;
  logic [31:0]      best_q;
  logic [CW:0]      rem_q;
  logic [DivW-1:0]  quo_q;
  logic [DcW-1:0]   dcnt_q;
  logic [CntOutW-1:0] kept_out_q, total_out_q;
  logic [RatioW-1:0]  ratio_q;
  logic               empty_q;

  always_comb begin
    re    = cmd_i.ins_rd | cmd_i.pre_rd | cmd_i.cand_rd;
    raddr = AW'(i_q - 1'b1);
    if (cmd_i.pre_rd)  raddr = AW'(k_q);
    if (cmd_i.cand_rd) raddr = AW'(id_q - 1'b1);
    we    = cmd_i.ins_shift | cmd_i.ins_put;
    waddr = AW'(i_q);
    wdata = cmd_i.ins_shift ? rd_q : d_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  // log unit, shared for n, id and the running sum
  logic [SW-1:0] log_x;
  logic          log_done;
  logic [LW-1:0] log_res;

  always_comb begin
    case (cmd_i.log_sel)
      LOG_N:   log_x = SW'(n_q);
      LOG_ID:  log_x = SW'(id_q);
      LOG_SUM: log_x = sum_q;
      default: log_x = '0;
    endcase
  end

  tro_log2 #(.SumW(SW)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_go),
    .x_i     (log_x),
    .done_o  (log_done),
    .res_o   (log_res)
  );

  logic [CfgW+CW-1:0]   min_prod, max_prod;
  logic [CfgW+1+LW-1:0] pen_prod;
  logic [CostW-1:0]     cost_w;
  logic [CW:0]          rem_sh;

  assign min_prod = CW'(count_q) * min_ratio_q;
  assign max_prod = CW'(count_q) * max_ratio_q;
  assign pen_prod = {lambda_q, 1'b0} * (ln_q - li_q);
  assign cost_w   = CostW'(ls_q) + CostW'(pen_q) - CostW'(li_q);
  assign rem_sh   = {rem_q[CW-1:0], quo_q[DivW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      best_q   <= '1;
      best_idx_q <= '0;
      keep_q   <= 1'b0;
      last_q   <= 1'b0;
      dcnt_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        d_q    <= distance_i;
        last_q <= last_i;
        keep_q <= !is_infinite_i && (distance_i != '0) && (count_q != CW'(MaxPoints));
        i_q    <= count_q;
      end
      if (cmd_i.ins_shift) i_q <= i_q - 1'b1;
      if (cmd_i.ins_put)   count_q <= count_q + 1'b1;
      if (cmd_i.setup) begin
        n_q        <= count_q;
        count_q    <= '0;
        min_el_q   <= min_prod[CfgW +: CW];
        max_el_q   <= max_prod[CfgW +: CW];
        best_q     <= '1;
        best_idx_q <= '0;
        sum_q      <= '0;
        k_q        <= '0;
        kept_out_q  <= '0;
        total_out_q <= '0;
        ratio_q     <= '0;
        empty_q     <= 1'b1;
      end
      if (log_done) begin
        case (cmd_i.log_sel)
          LOG_N:   ln_q <= log_res;
          LOG_ID:  li_q <= log_res;
          LOG_SUM: ls_q <= log_res;
          default: ;
        endcase
      end
      if (cmd_i.pre_acc) begin
        sum_q <= sum_q + SW'(rd_q);
        k_q   <= k_q + 1'b1;
      end
      if (cmd_i.cand_init) id_q <= min_el_q + 1'b1;
      if (cmd_i.cand_acc)  sum_q <= sum_q + SW'(rd_q);
      if (cmd_i.pen)       pen_q <= pen_prod[12 +: PW];
      if (cmd_i.cost) begin
        if (CmpW'(cost_w) < CmpW'(best_q)) begin
          best_q     <= 32'(cost_w);
          best_idx_q <= id_q - 1'b1 - min_el_q;
        end
        id_q <= id_q + 1'b1;
      end
      if (cmd_i.div_init) begin
        kept_q <= best_idx_q + min_el_q;
        quo_q  <= {best_idx_q + min_el_q, 16'd0};
        rem_q  <= '0;
        dcnt_q <= DcW'(DivW);
      end
      if (cmd_i.div_step) begin
        if (rem_sh >= {1'b0, n_q}) begin
          rem_q <= rem_sh - {1'b0, n_q};
          quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.fin) begin
        kept_out_q  <= CntOutW'(kept_q);
        total_out_q <= CntOutW'(n_q);
        ratio_q     <= (quo_q[DivW-1:16] != '0) ? '1 : quo_q[15:0];
        empty_q     <= 1'b0;
      end
    end
  end

  assign sts_o.keep     = keep_q;
  assign sts_o.last     = last_q;
  assign sts_o.i_zero   = (i_q == '0);
  assign sts_o.gt       = (rd_q > d_q);
  assign sts_o.n_zero   = (count_q == '0);
  assign sts_o.k_lt     = (k_q < min_el_q);
  assign sts_o.id_le    = (id_q <= max_el_q);
  assign sts_o.log_done = log_done;
  assign sts_o.div_done = (dcnt_q == '0);

  assign kept_count_o  = kept_out_q;
  assign total_count_o = total_out_q;
  assign ratio_o       = ratio_q;
  assign empty_error_o = empty_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxPoints))
    else $error("store count above depth");
  a_sorted_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ins_put && !sts_o.i_zero && $past(cmd_i.ins_rd)) |-> (rd_q <= d_q))
    else $error("insertion placed out of order");
  a_kept_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |=> (kept_q < n_q))
    else $error("kept count not below total");
`endif
endmodule
`default_nettype wire

/* rtl/trimmed_ratio_optimizer_top.sv */
// Sequence: an item is dropped (infinite, zero or store full) or inserted in sorted order,
// shifting each larger stored distance up one slot; the last item adds the search: a
// prefix sum, two serial leading-one searches per candidate count and a 27-step divide.
// Throughput: one item at a time; the store has one read and one write port.
// Reset: async active low; clears the set count, the best cost and index, the divide
// counter and the config registers to their defaults. The distance store is not cleared.
`default_nettype none
module trimmed_ratio_optimizer_top import tro_pkg::*; #(
  parameter int MaxPoints = DefMaxPoints
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [DistW-1:0]   distance_i,
  input  wire logic               is_infinite_i,
  input  wire logic               last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [CntOutW-1:0]      kept_count_o,
  output logic [CntOutW-1:0]      total_count_o,
  output logic [RatioW-1:0]       ratio_o,
  output logic                    empty_error_o
);
  // Commands flow down from the sequencer, status flows back up.
  tro_cmd_t    cmd;
  tro_status_t sts;

  tro_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store, prefix sum, log-domain cost compare and ratio divide.
  tro_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .distance_i    (distance_i),
    .is_infinite_i (is_infinite_i),
    .last_i        (last_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kept_count_o  (kept_count_o),
    .total_count_o (total_count_o),
    .ratio_o       (ratio_o),
    .empty_error_o (empty_error_o)
  );
endmodule
`default_nettype wire
